/* rtl/rgb_to_yuv_projective_assert.svh */
// Assertion macros shared by the RTL; clk and arst_n must be in scope.
`ifndef RGB_TO_YUV_PROJECTIVE_ASSERT_SVH
`define RGB_TO_YUV_PROJECTIVE_ASSERT_SVH

// same-cycle implication
`define RYP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RYP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ryp_pkg.sv */
package ryp_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MAXV_W     = 16;
	localparam int BIAS_W     = 10;
	localparam int K_W        = 11;
	localparam int BM_W       = 26;
	localparam int LUMA_W     = 17;
	localparam int CHROMA_W   = 18;
	localparam int QUOT_W     = 17;
	localparam int Q_DEPTH    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LUMA_BIAS = 2'd1;

	localparam logic [MAXV_W-1:0] MAXV_RST = 16'd255;
	localparam logic [BIAS_W-1:0] BIAS_RST = 10'd32;

	// coefficients in 1/1024 units
	localparam int C_YR  = 306;
	localparam int C_YG  = 601;
	localparam int C_YB  = 117;
	localparam int C_U   = 136;
	localparam int C_VR  = 169;
	localparam int C_VG  = 39;
	localparam int C_VB  = 130;
	localparam int K_ONE = 1024;

	localparam logic [LUMA_W-1:0]   LUMA_SAT   = 17'h1FFFF;
	localparam logic [CHROMA_W-1:0] CHROMA_POS = 18'h1FFFF;
	localparam logic [CHROMA_W-1:0] CHROMA_NEG = 18'h20000;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} ryp_front_stat_t;

	function automatic int yw(input int sb);
		return sb + 10;
	endfunction

	function automatic int mw(input int sb);
		return sb + 8;
	endfunction

	function automatic int d2w(input int sb);
		return ((yw(sb) > BM_W) ? yw(sb) : BM_W) + 2;
	endfunction

	function automatic int pw(input int sb);
		return yw(sb) + MAXV_W + K_W + d2w(sb) + 2 * mw(sb) + 3;
	endfunction

endpackage

/* rtl/ryp_queue.sv */
module ryp_queue #(
	parameter int W     = 8,
	parameter int DEPTH = ryp_pkg::Q_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr;
	logic          rd;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

/* rtl/ryp_front.sv */
module ryp_front #(
	parameter int SAMPLE_BITS = ryp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [15:0]                     red,
	input  logic [15:0]                     green,
	input  logic [15:0]                     blue,
	input  logic [ryp_pkg::MAXV_W-1:0]      max_value,
	input  logic [ryp_pkg::BIAS_W-1:0]      luma_bias,
	input  logic                            q_full,
	output logic                            q_push,
	output logic [ryp_pkg::pw(SAMPLE_BITS)-1:0] q_wdata,
	output ryp_pkg::ryp_front_stat_t        stat
);

	localparam int SB   = SAMPLE_BITS;
	localparam int YW   = ryp_pkg::yw(SB);
	localparam int MW   = ryp_pkg::mw(SB);
	localparam int D2W  = ryp_pkg::d2w(SB);
	localparam int BMW  = ryp_pkg::BM_W;
	localparam int KW   = ryp_pkg::K_W;
	localparam int MXW  = ryp_pkg::MAXV_W;

	logic           fen;
	logic [SB-1:0]  r;
	logic [SB-1:0]  g;
	logic [SB-1:0]  b;
	logic [MXW-1:0] m_eff;

	logic           v_s1;
	logic [YW-1:0]  ys_s1;
	logic [MW-1:0]  vp_s1;
	logic [MW-1:0]  vn_s1;
	logic [SB-1:0]  du_s1;
	logic           nu_s1;
	logic [BMW-1:0] bm_s1;
	logic [MXW-1:0] m_s1;
	logic [KW-1:0]  k_s1;

	logic [D2W-1:0] sum2;
	logic [D2W-1:0] d2_c;

	logic           v_s2;
	logic [YW-1:0]  ys_s2;
	logic [MXW-1:0] m_s2;
	logic [KW-1:0]  k_s2;
	logic [D2W-1:0] d2_s2;
	logic [MW-1:0]  mu_s2;
	logic [MW-1:0]  mv_s2;
	logic           nu_s2;
	logic           nv_s2;
	logic           zero_s2;

	// stall only when stage 2 holds an item the queue cannot take
	assign fen    = !(v_s2 && q_full);
	assign full   = !fen;
	assign q_push = v_s2 && !q_full;

	assign r     = red[SB-1:0];
	assign g     = green[SB-1:0];
	assign b     = blue[SB-1:0];
	assign m_eff = (max_value == '0) ? MXW'(1) : max_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fen) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			ys_s1 <= YW'(r) * YW'(ryp_pkg::C_YR) + YW'(g) * YW'(ryp_pkg::C_YG)
				+ YW'(b) * YW'(ryp_pkg::C_YB);
			vp_s1 <= MW'(b) * MW'(ryp_pkg::C_VB) + MW'(g) * MW'(ryp_pkg::C_VG);
			vn_s1 <= MW'(r) * MW'(ryp_pkg::C_VR);
			du_s1 <= (r >= g) ? (r - g) : (g - r);
			nu_s1 <= (r < g);
			bm_s1 <= BMW'(luma_bias) * BMW'(m_eff);
			m_s1  <= m_eff;
			k_s1  <= KW'(ryp_pkg::K_ONE) + KW'(luma_bias);
		end
	end

	// 2048 times the correction divisor, floored at half the bias term
	assign sum2 = (D2W'(ys_s1) + D2W'(bm_s1)) << 1;
	assign d2_c = (sum2 <= D2W'(bm_s1)) ? D2W'(bm_s1) : sum2;

	always_ff @(posedge clk) begin
		if (fen) begin
			ys_s2   <= ys_s1;
			m_s2    <= m_s1;
			k_s2    <= k_s1;
			d2_s2   <= d2_c;
			mu_s2   <= MW'(du_s1) * MW'(ryp_pkg::C_U);
			mv_s2   <= (vp_s1 >= vn_s1) ? (vp_s1 - vn_s1) : (vn_s1 - vp_s1);
			nu_s2   <= nu_s1;
			nv_s2   <= (vp_s1 < vn_s1);
			zero_s2 <= (d2_c == '0);
		end
	end

	assign q_wdata = {ys_s2, m_s2, k_s2, d2_s2, mu_s2, mv_s2, nu_s2, nv_s2, zero_s2};

	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;

endmodule

/* rtl/ryp_div.sv */
module ryp_div #(
	parameter int NW = 44,
	parameter int DW = 29,
	parameter int QW = ryp_pkg::QUOT_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot,
	output logic          ovf
);

	localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [WW-1:0] rem_q [QW];
	logic [DW-1:0] d_q   [QW];
	logic [QW-1:0] quo_q [QW+1];
	logic          ovf_q [QW+1];

	// stage 0 flags a quotient that does not fit, then one bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= WW'(num);
			d_q[0]   <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= (WW'(num) >= (WW'(den) << QW));
			for (int j = 1; j <= QW; j++) begin
				logic [WW-1:0] trial;
				trial = WW'(d_q[j-1]) << (QW - j);
				ovf_q[j] <= ovf_q[j-1];
				if (rem_q[j-1] >= trial) begin
					quo_q[j] <= quo_q[j-1] | (QW'(1) << (QW - j));
				end else begin
					quo_q[j] <= quo_q[j-1];
				end
				if (j < QW) begin
					d_q[j % QW]   <= d_q[j-1];
					rem_q[j % QW] <= (rem_q[j-1] >= trial) ? rem_q[j-1] - trial
						: rem_q[j-1];
				end
			end
		end
	end

	assign quot = quo_q[QW];
	assign ovf  = ovf_q[QW];

endmodule

/* rtl/ryp_back.sv */
module ryp_back #(
	parameter int SAMPLE_BITS = ryp_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = ryp_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  logic [ryp_pkg::pw(SAMPLE_BITS)-1:0] q_rdata,
	output logic                                q_pop,
	input  logic                                pop,
	output logic                                empty,
	output logic [ryp_pkg::LUMA_W-1:0]          luma,
	output logic signed [ryp_pkg::CHROMA_W-1:0] chroma_u,
	output logic signed [ryp_pkg::CHROMA_W-1:0] chroma_v
);

	localparam int SB  = SAMPLE_BITS;
	localparam int YW  = ryp_pkg::yw(SB);
	localparam int MW  = ryp_pkg::mw(SB);
	localparam int D2W = ryp_pkg::d2w(SB);
	localparam int KW  = ryp_pkg::K_W;
	localparam int MXW = ryp_pkg::MAXV_W;
	localparam int QW  = ryp_pkg::QUOT_W;
	localparam int PRW = MW + KW;
	localparam int LNW = YW + FRAC_BITS + 1;
	localparam int LDW = MXW + 10;
	localparam int CNA = PRW + FRAC_BITS - 8;
	localparam int CNW = ((CNA > D2W) ? CNA : D2W) + 1;
	localparam int CDW = D2W + 1;
	localparam int LAT = QW + 1;
	localparam int CHW = ryp_pkg::CHROMA_W;

	logic           en;
	logic           take;
	logic [YW-1:0]  f_ys;
	logic [MXW-1:0] f_m;
	logic [KW-1:0]  f_k;
	logic [D2W-1:0] f_d2;
	logic [MW-1:0]  f_mu;
	logic [MW-1:0]  f_mv;
	logic           f_nu;
	logic           f_nv;
	logic           f_zero;

	logic           v_s3;
	logic [PRW-1:0] pu_s3;
	logic [PRW-1:0] pv_s3;
	logic [D2W-1:0] d2_s3;
	logic [YW-1:0]  ys_s3;
	logic [MXW-1:0] m_s3;
	logic           nu_s3;
	logic           nv_s3;
	logic           zero_s3;

	logic [LNW-1:0] l_num;
	logic [LDW-1:0] l_den;
	logic [CNW-1:0] u_num;
	logic [CNW-1:0] v_num;
	logic [CDW-1:0] c_den;

	logic [QW-1:0]  l_q;
	logic [QW-1:0]  u_q;
	logic [QW-1:0]  v_q;
	logic           l_ovf;
	logic           u_ovf;
	logic           v_ovf;

	logic           vld_q  [LAT];
	logic           nu_q   [LAT];
	logic           nv_q   [LAT];
	logic           zero_q [LAT];

	logic                  out_v_q;
	logic [ryp_pkg::LUMA_W-1:0] luma_q;
	logic [CHW-1:0]        cu_q;
	logic [CHW-1:0]        cv_q;

	function automatic logic [CHW-1:0] chroma_fix(input logic [QW-1:0] q, input logic ov,
			input logic neg, input logic zr);
		logic [CHW-1:0] mag;
		mag = CHW'(q);
		if (zr) begin
			return '0;
		end else if (ov) begin
			return neg ? ryp_pkg::CHROMA_NEG : ryp_pkg::CHROMA_POS;
		end else begin
			return neg ? (~mag + 1'b1) : mag;
		end
	endfunction

	// whole back end advances together; it holds only while a result waits unpopped
	assign en    = !out_v_q || pop;
	assign take  = en && !q_empty;
	assign q_pop = take;
	assign empty = !out_v_q;

	assign {f_ys, f_m, f_k, f_d2, f_mu, f_mv, f_nu, f_nv, f_zero} = q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s3     <= take;
			vld_q[0] <= v_s3;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			out_v_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pu_s3   <= PRW'(f_mu) * PRW'(f_k);
			pv_s3   <= PRW'(f_mv) * PRW'(f_k);
			d2_s3   <= f_d2;
			ys_s3   <= f_ys;
			m_s3    <= f_m;
			nu_s3   <= f_nu;
			nv_s3   <= f_nv;
			zero_s3 <= f_zero;
			nu_q[0]   <= nu_s3;
			nv_q[0]   <= nv_s3;
			zero_q[0] <= zero_s3;
			for (int i = 1; i < LAT; i++) begin
				nu_q[i]   <= nu_q[i-1];
				nv_q[i]   <= nv_q[i-1];
				zero_q[i] <= zero_q[i-1];
			end
			luma_q <= l_ovf ? ryp_pkg::LUMA_SAT : l_q;
			cu_q   <= chroma_fix(u_q, u_ovf, nu_q[LAT-1], zero_q[LAT-1]);
			cv_q   <= chroma_fix(v_q, v_ovf, nv_q[LAT-1], zero_q[LAT-1]);
		end
	end

	// rounded quotients as floor((2a + d) / 2d)
	assign l_num = (LNW'(ys_s3) << FRAC_BITS) + (LNW'(m_s3) << 9);
	assign l_den = LDW'(m_s3) << 10;
	assign u_num = (CNW'(pu_s3) << (FRAC_BITS - 8)) + CNW'(d2_s3);
	assign v_num = (CNW'(pv_s3) << (FRAC_BITS - 8)) + CNW'(d2_s3);
	assign c_den = CDW'(d2_s3) << 1;

	ryp_div #(.NW(LNW), .DW(LDW), .QW(QW)) u_div_l (
		.clk(clk), .en(en), .num(l_num), .den(l_den), .quot(l_q), .ovf(l_ovf)
	);

	ryp_div #(.NW(CNW), .DW(CDW), .QW(QW)) u_div_u (
		.clk(clk), .en(en), .num(u_num), .den(c_den), .quot(u_q), .ovf(u_ovf)
	);

	ryp_div #(.NW(CNW), .DW(CDW), .QW(QW)) u_div_v (
		.clk(clk), .en(en), .num(v_num), .den(c_den), .quot(v_q), .ovf(v_ovf)
	);

	assign luma     = luma_q;
	assign chroma_u = cu_q;
	assign chroma_v = cv_q;

endmodule

/* rtl/rgb_to_yuv_projective.sv */
// RGB to luma plus projectively corrected chroma, one pixel per clock when not stalled.
// Input channel: queue-style push/full. A transaction happens on a rising
//   edge with push high and full low; red/green/blue are sampled then.
// Result channel: queue-style empty/pop. While empty is low the oldest
//   result sits on luma/chroma_u/chroma_v; pop high takes it.
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data. Index 0 is
//   max_value, index 1 is luma_bias; other indexes are dropped. cfg_ready
//   is always high. Write only while the block is drained.
// Pipeline: after the input transaction a pixel passes, when nothing stalls,
//   the second front stage, queue write, 1 multiply stage, 18 divider
//   stages and the output register before empty goes low. Throughput: one
//   pixel per cycle while nothing stalls, set by the three pipelined
//   restoring dividers that each retire a quotient bit per stage.
// Stalls: while a result is held unpopped, the back end freezes; the
//   4-entry queue between the front and back ends absorbs pixels, and full
//   rises once it is full and the second front stage holds a pixel.
// Reset: arst_n clears all valid state (block empty, full low) and loads
//   max_value = 255, luma_bias = 32.
`include "rgb_to_yuv_projective_assert.svh"

module rgb_to_yuv_projective #(
	parameter int SAMPLE_BITS = ryp_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = ryp_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [15:0]                          red,
	input  logic [15:0]                          green,
	input  logic [15:0]                          blue,
	input  logic                                 pop,
	output logic                                 empty,
	output logic [ryp_pkg::LUMA_W-1:0]           luma,
	output logic signed [ryp_pkg::CHROMA_W-1:0]  chroma_u,
	output logic signed [ryp_pkg::CHROMA_W-1:0]  chroma_v,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ryp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ryp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int PW = ryp_pkg::pw(SAMPLE_BITS);

	logic [ryp_pkg::MAXV_W-1:0] maxv_q;
	logic [ryp_pkg::BIAS_W-1:0] bias_q;

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic [PW-1:0] q_wdata;
	logic [PW-1:0] q_rdata;

	ryp_pkg::ryp_front_stat_t fstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxv_q <= ryp_pkg::MAXV_RST;
			bias_q <= ryp_pkg::BIAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ryp_pkg::REG_MAX_VALUE: maxv_q <= cfg_data[ryp_pkg::MAXV_W-1:0];
				ryp_pkg::REG_LUMA_BIAS: bias_q <= cfg_data[ryp_pkg::BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	// front: sample products, bias term, divisor selection, chroma sign split
	ryp_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.max_value (maxv_q),
		.luma_bias (bias_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata),
		.stat      (fstat)
	);

	// decoupling queue between the two halves
	ryp_queue #(.W(PW), .DEPTH(ryp_pkg::Q_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	// back: gain multiply, three dividers, saturation, output register
	ryp_back #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.luma     (luma),
		.chroma_u (chroma_u),
		.chroma_v (chroma_v)
	);

	// queue can never look both full and empty
	`RYP_ASSERT_NOW(a_queue_state, q_full, !q_empty, "queue full and empty at once")
	// a stalled front stays stalled until the back end drains an entry
	`RYP_ASSERT_NEXT(a_full_holds, full && !q_pop, full, "full dropped without a queue pop")
	// full only when the front holds an item the queue cannot take
	`RYP_ASSERT_NOW(a_full_cause, full, fstat.v_s2 && q_full, "full without backed-up front")

endmodule
